### sv/fjs_pkg.sv
// ----------------------------------------------------------------------------
// fjs_pkg: flat JSON object scanner shared definitions
// Codes, closer markers, stack command structs and character helpers.
// ----------------------------------------------------------------------------
package fjs_pkg;

    localparam int MAX_DOC_BYTES_DEF = 65536;
    localparam int NEST_DEPTH_DEF    = 64;

    localparam logic [10:0] MAX_PROPS_RESET = 11'd64;

    // Error codes
    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_JUNK_OPEN  = 4'd1;
    localparam logic [3:0] ERR_KEY_START  = 4'd2;
    localparam logic [3:0] ERR_EMPTY_KEY  = 4'd3;
    localparam logic [3:0] ERR_EARLY_END  = 4'd4;
    localparam logic [3:0] ERR_NO_COLON   = 4'd5;
    localparam logic [3:0] ERR_VAL_START  = 4'd6;
    localparam logic [3:0] ERR_BAD_TOKEN  = 4'd7;
    localparam logic [3:0] ERR_MISMATCH   = 4'd8;
    localparam logic [3:0] ERR_JUNK_AFTER = 4'd9;
    localparam logic [3:0] ERR_TRAILING   = 4'd10;
    localparam logic [3:0] ERR_TOO_MANY   = 4'd11;
    localparam logic [3:0] ERR_OVERFLOW   = 4'd12;

    // Value kinds
    localparam logic [2:0] KIND_STRING = 3'd0;
    localparam logic [2:0] KIND_NUMBER = 3'd1;
    localparam logic [2:0] KIND_NULL   = 3'd2;
    localparam logic [2:0] KIND_TRUE   = 3'd3;
    localparam logic [2:0] KIND_FALSE  = 3'd4;
    localparam logic [2:0] KIND_OBJECT = 3'd5;
    localparam logic [2:0] KIND_ARRAY  = 3'd6;

    // Closer stack entries
    localparam logic [1:0] CL_BRACE   = 2'd1;
    localparam logic [1:0] CL_BRACKET = 2'd2;
    localparam logic [1:0] CL_QUOTE   = 2'd3;

    typedef struct packed {
        logic       clear;
        logic       push;
        logic       pop;
        logic [1:0] code;
    } stk_cmd_t;

    typedef struct packed {
        logic [1:0] tos;
    } stk_stat_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // Keyword letter k (0 null, 1 true, 2 false) at index idx matches c
    function automatic logic kw_hit(input logic [1:0] k, input logic [2:0] idx,
                                    input logic [7:0] c);
        logic [7:0] ch;
        logic       inlen;
        ch    = 8'h00;
        inlen = 1'b0;
        case (k)
            2'd0:
            begin
                inlen = idx < 3'd4;
                case (idx)
                    3'd0:    ch = "n";
                    3'd1:    ch = "u";
                    default: ch = "l";
                endcase
            end
            2'd1:
            begin
                inlen = idx < 3'd4;
                case (idx)
                    3'd0:    ch = "t";
                    3'd1:    ch = "r";
                    3'd2:    ch = "u";
                    default: ch = "e";
                endcase
            end
            default:
            begin
                inlen = idx < 3'd5;
                case (idx)
                    3'd0:    ch = "f";
                    3'd1:    ch = "a";
                    3'd2:    ch = "l";
                    3'd3:    ch = "s";
                    default: ch = "e";
                endcase
            end
        endcase
        return inlen && (c == ch);
    endfunction

endpackage

### sv/fjs_ram.sv
// ----------------------------------------------------------------------------
// fjs_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fjs_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/fjs_stack.sv
// ----------------------------------------------------------------------------
// fjs_stack: closer stack for nested values
// Top entry cached in a register; the entry below is read ahead from RAM.
// ----------------------------------------------------------------------------
module fjs_stack #(
    parameter int NEST_DEPTH = fjs_pkg::NEST_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fjs_pkg::stk_cmd_t             cmd,
    output fjs_pkg::stk_stat_t            stat,
    output logic [$clog2(NEST_DEPTH+1)-1:0] depth
);

    localparam int DW = $clog2(NEST_DEPTH + 1);
    localparam int AW = $clog2(NEST_DEPTH);

    logic [DW-1:0] depth_reg, depth_next, depth_base;
    logic [1:0]    tos_reg, tos_next;
    logic [1:0]    below;
    logic [DW-1:0] rd_idx;

    always_comb
    begin
        depth_base = cmd.clear ? '0 : depth_reg;
        depth_next = depth_base;
        tos_next   = tos_reg;
        if (cmd.push)
        begin
            depth_next = depth_base + DW'(1);
            tos_next   = cmd.code;
        end
        else if (cmd.pop)
        begin
            depth_next = depth_base - DW'(1);
            tos_next   = below;
        end
        // prefetch the entry under the new top
        rd_idx = depth_next - DW'(2);
    end

    fjs_ram #(
        .WIDTH (2),
        .DEPTH (NEST_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (depth_base[AW-1:0]),
        .wdata (cmd.code),
        .raddr (rd_idx[AW-1:0]),
        .rdata (below)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            tos_reg   <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
            tos_reg   <= tos_next;
        end
    end

    assign stat.tos = tos_reg;
    assign depth    = depth_reg;

endmodule

### sv/flat_json_object_scanner.sv
// ----------------------------------------------------------------------------
// flat_json_object_scanner: streaming scanner for one flat JSON object
// Takes one document byte per beat and returns one result beat per byte.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | sink      | in_valid / in_stall    | text_byte, is_final
//  out     | source    | out_valid / out_stall  | property_ready .. error_code
//  cfg     | sink      | cfg_write              | cfg_data (max_properties)
//
//  One byte per cycle unless out_stall holds a finished beat: each accepted byte
//  updates all state in that cycle; its result beat appears in the output
//  register on the next cycle. The closer stack lives in a RAM; its top is
//  cached and the entry below is read ahead, so a pop never stalls the input.
//  Reset returns to the seek-brace phase with max_properties = 64.
//  in_stall rises only when a finished beat is held by out_stall.
// ----------------------------------------------------------------------------
module flat_json_object_scanner #(
    parameter int MAX_DOC_BYTES = fjs_pkg::MAX_DOC_BYTES_DEF,
    parameter int NEST_DEPTH    = fjs_pkg::NEST_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_byte,
    input  logic        is_final,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        property_ready,
    output logic [15:0] key_offset,
    output logic [15:0] key_length,
    output logic [15:0] value_offset,
    output logic [15:0] value_length,
    output logic [2:0]  value_kind,
    output logic [10:0] property_total,
    output logic        document_ok,
    output logic [3:0]  error_code,
    input  logic        cfg_write,
    input  logic [10:0] cfg_data
);

    localparam int PW = $clog2(MAX_DOC_BYTES);
    localparam int DW = $clog2(NEST_DEPTH + 1);
    localparam int EW = (PW + 1 > 16) ? PW + 1 : 16;
    localparam logic [PW:0]   DOC_BYTES = (PW+1)'(MAX_DOC_BYTES);
    localparam logic [PW-1:0] LAST_POS  = PW'(MAX_DOC_BYTES - 1);
    localparam logic [DW-1:0] DEPTH_MAX = DW'(NEST_DEPTH);

    typedef enum logic [9:0] {
        PH_OPEN    = 10'b0000000001,
        PH_KEY     = 10'b0000000010,
        PH_KEYBODY = 10'b0000000100,
        PH_COLON   = 10'b0000001000,
        PH_VAL     = 10'b0000010000,
        PH_STR     = 10'b0000100000,
        PH_TOKEN   = 10'b0001000000,
        PH_NEST    = 10'b0010000000,
        PH_COMMA   = 10'b0100000000,
        PH_TAIL    = 10'b1000000000
    } phase_t;

    // Modular distance from 'from' to 'to' inside the position window
    function automatic logic [PW:0] span(input logic [PW-1:0] from, input logic [PW-1:0] to);
        if (to >= from)
        begin
            return {1'b0, to} - {1'b0, from};
        end
        return {1'b0, to} + DOC_BYTES - {1'b0, from};
    endfunction

    function automatic logic [15:0] low16(input logic [PW:0] x);
        logic [EW-1:0] t;
        t = EW'(x);
        return t[15:0];
    endfunction

    // ---- state ----
    phase_t        phase_reg, phase_next;
    logic [PW-1:0] pos_reg, pos_next, pos_inc;
    logic [PW-1:0] key_start_reg, key_start_next;
    logic [PW-1:0] key_len_reg, key_len_next;
    logic [PW-1:0] val_start_reg, val_start_next;
    logic [2:0]    nest_kind_reg, nest_kind_next;
    logic [2:0]    tok_len_reg, tok_len_next;
    logic [2:0]    kw_match_reg, kw_match_next;
    logic          tok_zero_reg, tok_zero_next;
    logic          tok_minus_reg, tok_minus_next;
    logic          tok_num_reg, tok_num_next;
    logic          tok_dot_reg, tok_dot_next;
    logic [10:0]   count_reg, count_next;
    logic [3:0]    err_reg, err_next;
    logic [10:0]   max_props_reg;

    // ---- output register ----
    logic          out_valid_reg, out_valid_next;
    logic          o_ready_reg, o_ready_next;
    logic [15:0]   o_koff_reg, o_koff_next, o_klen_reg, o_klen_next;
    logic [15:0]   o_voff_reg, o_voff_next, o_vlen_reg, o_vlen_next;
    logic [2:0]    o_kind_reg, o_kind_next;
    logic [10:0]   o_total_reg, o_total_next;
    logic          o_ok_reg, o_ok_next;
    logic [3:0]    o_err_reg, o_err_next;

    // ---- stack ----
    fjs_pkg::stk_cmd_t  cmd, stk_cmd;
    fjs_pkg::stk_stat_t stk_stat;
    logic [DW-1:0]      stk_depth;

    // ---- token feed ----
    logic [2:0] f_len_in, f_len, f_match_in, f_match;
    logic       f_zero_in, f_minus_in, f_num_in, f_dot_in;
    logic       f_zero, f_minus, f_num, f_dot;
    logic [2:0] tk_kind;
    logic       tk_ok;

    logic       accept;
    logic       do_done;
    logic [2:0] done_kind;
    logic [PW:0] done_len;
    logic [7:0] c;
    logic [1:0] close_code;
    logic [3:0] err_fin;

    assign accept   = in_valid & ~in_stall;
    assign in_stall = out_valid_reg & out_stall;
    assign c        = text_byte;
    assign pos_inc  = (pos_reg == LAST_POS) ? '0 : pos_reg + PW'(1);

    // Feed one byte to the token checker; a value start begins from a fresh token
    always_comb
    begin
        if (phase_reg == PH_VAL)
        begin
            f_len_in   = 3'd0;
            f_match_in = 3'b111;
            f_zero_in  = 1'b0;
            f_minus_in = 1'b0;
            f_num_in   = 1'b0;
            f_dot_in   = 1'b0;
        end
        else
        begin
            f_len_in   = tok_len_reg;
            f_match_in = kw_match_reg;
            f_zero_in  = tok_zero_reg;
            f_minus_in = tok_minus_reg;
            f_num_in   = tok_num_reg;
            f_dot_in   = tok_dot_reg;
        end
        for (int k = 0; k < 3; k++)
        begin
            f_match[k] = f_match_in[k] & fjs_pkg::kw_hit(2'(k), f_len_in, c);
        end
        f_zero  = f_zero_in;
        f_minus = f_minus_in;
        f_num   = f_num_in;
        f_dot   = f_dot_in;
        if (f_len_in == 3'd0)
        begin
            f_zero  = (c == "0");
            f_minus = (c == "-");
            f_num   = fjs_pkg::is_digit(c) || (c == "-");
            f_dot   = 1'b0;
        end
        else if (f_zero_in)
        begin
            f_num = 1'b0;
        end
        else if (f_dot_in)
        begin
            f_num = f_num_in & fjs_pkg::is_digit(c);
        end
        else if (c == ".")
        begin
            f_dot = 1'b1;
        end
        else
        begin
            f_num = f_num_in & fjs_pkg::is_digit(c);
        end
        f_len = (f_len_in < 3'd7) ? f_len_in + 3'd1 : f_len_in;
    end

    // Classify the finished token
    always_comb
    begin
        tk_ok   = 1'b1;
        tk_kind = fjs_pkg::KIND_STRING;
        if (tok_num_reg && !(tok_len_reg == 3'd1 && tok_minus_reg))
        begin
            tk_kind = fjs_pkg::KIND_NUMBER;
        end
        else if (tok_len_reg == 3'd4 && kw_match_reg[0])
        begin
            tk_kind = fjs_pkg::KIND_NULL;
        end
        else if (tok_len_reg == 3'd4 && kw_match_reg[1])
        begin
            tk_kind = fjs_pkg::KIND_TRUE;
        end
        else if (tok_len_reg == 3'd5 && kw_match_reg[2])
        begin
            tk_kind = fjs_pkg::KIND_FALSE;
        end
        else
        begin
            tk_ok = 1'b0;
        end
    end

    // Phase machine
    always_comb
    begin
        phase_next     = phase_reg;
        key_start_next = key_start_reg;
        key_len_next   = key_len_reg;
        val_start_next = val_start_reg;
        nest_kind_next = nest_kind_reg;
        tok_len_next   = tok_len_reg;
        kw_match_next  = kw_match_reg;
        tok_zero_next  = tok_zero_reg;
        tok_minus_next = tok_minus_reg;
        tok_num_next   = tok_num_reg;
        tok_dot_next   = tok_dot_reg;
        count_next     = count_reg;
        err_next       = err_reg;
        cmd            = '0;
        do_done        = 1'b0;
        done_kind      = fjs_pkg::KIND_STRING;
        done_len       = '0;
        close_code     = (c == "}") ? fjs_pkg::CL_BRACE : fjs_pkg::CL_BRACKET;

        o_ready_next = 1'b0;
        o_koff_next  = '0;
        o_klen_next  = '0;
        o_voff_next  = '0;
        o_vlen_next  = '0;
        o_kind_next  = '0;

        if (err_reg == fjs_pkg::ERR_NONE)
        begin
            unique case (phase_reg)
                PH_OPEN:
                begin
                    if (c == "{")
                        phase_next = PH_KEY;
                    else if (!fjs_pkg::is_ws(c))
                        err_next = fjs_pkg::ERR_JUNK_OPEN;
                end
                PH_KEY:
                begin
                    if (c == "}")
                        phase_next = PH_TAIL;
                    else if (c == "\"")
                    begin
                        key_start_next = pos_inc;
                        phase_next     = PH_KEYBODY;
                    end
                    else if (!fjs_pkg::is_ws(c))
                        err_next = fjs_pkg::ERR_KEY_START;
                end
                PH_KEYBODY:
                begin
                    if (c == "\"")
                    begin
                        key_len_next = PW'(span(key_start_reg, pos_reg));
                        if (key_len_next == '0)
                            err_next = fjs_pkg::ERR_EMPTY_KEY;
                        else
                            phase_next = PH_COLON;
                    end
                end
                PH_COLON:
                begin
                    if (c == ":")
                        phase_next = PH_VAL;
                    else if (!fjs_pkg::is_ws(c))
                        err_next = fjs_pkg::ERR_NO_COLON;
                end
                PH_VAL:
                begin
                    if (fjs_pkg::is_ws(c))
                    begin
                    end
                    else if (c == "}" || c == "]" || c == "(" || c == ")")
                        err_next = fjs_pkg::ERR_VAL_START;
                    else if (c == "\"")
                    begin
                        val_start_next = pos_inc;
                        phase_next     = PH_STR;
                    end
                    else if (c == "{" || c == "[")
                    begin
                        val_start_next = pos_reg;
                        nest_kind_next = (c == "{") ? fjs_pkg::KIND_OBJECT
                                                    : fjs_pkg::KIND_ARRAY;
                        cmd.clear      = 1'b1;
                        cmd.push       = 1'b1;
                        cmd.code       = (c == "{") ? fjs_pkg::CL_BRACE
                                                    : fjs_pkg::CL_BRACKET;
                        phase_next     = PH_NEST;
                    end
                    else if (c == ",")
                        err_next = fjs_pkg::ERR_BAD_TOKEN;
                    else
                    begin
                        val_start_next = pos_reg;
                        tok_len_next   = f_len;
                        kw_match_next  = f_match;
                        tok_zero_next  = f_zero;
                        tok_minus_next = f_minus;
                        tok_num_next   = f_num;
                        tok_dot_next   = f_dot;
                        phase_next     = PH_TOKEN;
                    end
                end
                PH_STR:
                begin
                    if (c == "\"")
                    begin
                        do_done    = 1'b1;
                        done_kind  = fjs_pkg::KIND_STRING;
                        done_len   = span(val_start_reg, pos_reg);
                        phase_next = PH_COMMA;
                    end
                end
                PH_TOKEN:
                begin
                    if (fjs_pkg::is_ws(c) || c == "," || c == "}")
                    begin
                        if (!tk_ok)
                            err_next = fjs_pkg::ERR_BAD_TOKEN;
                        else
                        begin
                            do_done    = 1'b1;
                            done_kind  = tk_kind;
                            done_len   = span(val_start_reg, pos_reg);
                            phase_next = (c == ",") ? PH_KEY :
                                         (c == "}") ? PH_TAIL : PH_COMMA;
                        end
                    end
                    else
                    begin
                        tok_len_next   = f_len;
                        kw_match_next  = f_match;
                        tok_zero_next  = f_zero;
                        tok_minus_next = f_minus;
                        tok_num_next   = f_num;
                        tok_dot_next   = f_dot;
                    end
                end
                PH_NEST:
                begin
                    if (stk_depth == '0)
                        err_next = fjs_pkg::ERR_MISMATCH;
                    else if (c == "\"" && stk_depth != DW'(1)
                             && stk_stat.tos == fjs_pkg::CL_QUOTE)
                        cmd.pop = 1'b1;
                    else if (c == "\"" || c == "{" || c == "[")
                    begin
                        // push, or flag overflow on a full stack
                        if (stk_depth >= DEPTH_MAX)
                            err_next = fjs_pkg::ERR_OVERFLOW;
                        else
                        begin
                            cmd.push = 1'b1;
                            cmd.code = (c == "\"") ? fjs_pkg::CL_QUOTE :
                                       (c == "{")  ? fjs_pkg::CL_BRACE
                                                   : fjs_pkg::CL_BRACKET;
                        end
                    end
                    else if (c == "}" || c == "]")
                    begin
                        if (close_code != stk_stat.tos)
                            err_next = fjs_pkg::ERR_MISMATCH;
                        else if (stk_depth == DW'(1))
                        begin
                            cmd.clear  = 1'b1;
                            do_done    = 1'b1;
                            done_kind  = nest_kind_reg;
                            done_len   = span(val_start_reg, pos_reg) + (PW+1)'(1);
                            phase_next = PH_COMMA;
                        end
                        else
                            cmd.pop = 1'b1;
                    end
                end
                PH_COMMA:
                begin
                    if (c == ",")
                        phase_next = PH_KEY;
                    else if (c == "}")
                        phase_next = PH_TAIL;
                    else if (!fjs_pkg::is_ws(c))
                        err_next = fjs_pkg::ERR_JUNK_AFTER;
                end
                PH_TAIL:
                begin
                    if (!fjs_pkg::is_ws(c))
                        err_next = fjs_pkg::ERR_TRAILING;
                end
                default:
                    phase_next = PH_OPEN;
            endcase
        end

        // Property done: report it, or reject it past the limit
        if (do_done)
        begin
            if (count_reg >= max_props_reg)
                err_next = fjs_pkg::ERR_TOO_MANY;
            else
            begin
                count_next   = count_reg + 11'd1;
                o_ready_next = 1'b1;
                o_koff_next  = low16({1'b0, key_start_reg});
                o_klen_next  = low16({1'b0, key_len_reg});
                o_voff_next  = low16({1'b0, val_start_reg});
                o_vlen_next  = low16(done_len);
                o_kind_next  = done_kind;
            end
        end

        pos_next     = pos_inc;
        o_total_next = count_next;
        err_fin      = err_next;
        o_ok_next    = 1'b0;
        if (is_final)
        begin
            if (err_next == fjs_pkg::ERR_NONE && phase_next != PH_TAIL)
                err_fin = fjs_pkg::ERR_EARLY_END;
            o_ok_next = (err_fin == fjs_pkg::ERR_NONE);
            // drop the document state for the next one
            phase_next     = PH_OPEN;
            pos_next       = '0;
            key_start_next = '0;
            key_len_next   = '0;
            val_start_next = '0;
            nest_kind_next = '0;
            tok_len_next   = '0;
            kw_match_next  = '0;
            tok_zero_next  = 1'b0;
            tok_minus_next = 1'b0;
            tok_num_next   = 1'b0;
            tok_dot_next   = 1'b0;
            count_next     = '0;
            err_next       = fjs_pkg::ERR_NONE;
            cmd            = '0;
            cmd.clear      = 1'b1;
        end
        o_err_next = err_fin;
    end

    assign stk_cmd        = accept ? cmd : '0;
    assign out_valid_next = accept ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    fjs_stack #(
        .NEST_DEPTH (NEST_DEPTH)
    ) u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (stk_cmd),
        .stat  (stk_stat),
        .depth (stk_depth)
    );

    // Document state advances only on an accepted beat; max_props and out_valid update on their own
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_OPEN;
            pos_reg       <= '0;
            key_start_reg <= '0;
            key_len_reg   <= '0;
            val_start_reg <= '0;
            nest_kind_reg <= '0;
            tok_len_reg   <= '0;
            kw_match_reg  <= '0;
            tok_zero_reg  <= 1'b0;
            tok_minus_reg <= 1'b0;
            tok_num_reg   <= 1'b0;
            tok_dot_reg   <= 1'b0;
            count_reg     <= '0;
            err_reg       <= fjs_pkg::ERR_NONE;
            max_props_reg <= fjs_pkg::MAX_PROPS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                max_props_reg <= cfg_data;
            if (accept)
            begin
                phase_reg     <= phase_next;
                pos_reg       <= pos_next;
                key_start_reg <= key_start_next;
                key_len_reg   <= key_len_next;
                val_start_reg <= val_start_next;
                nest_kind_reg <= nest_kind_next;
                tok_len_reg   <= tok_len_next;
                kw_match_reg  <= kw_match_next;
                tok_zero_reg  <= tok_zero_next;
                tok_minus_reg <= tok_minus_next;
                tok_num_reg   <= tok_num_next;
                tok_dot_reg   <= tok_dot_next;
                count_reg     <= count_next;
                err_reg       <= err_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload: load on accept, hold while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            o_ready_reg <= o_ready_next;
            o_koff_reg  <= o_koff_next;
            o_klen_reg  <= o_klen_next;
            o_voff_reg  <= o_voff_next;
            o_vlen_reg  <= o_vlen_next;
            o_kind_reg  <= o_kind_next;
            o_total_reg <= o_total_next;
            o_ok_reg    <= o_ok_next;
            o_err_reg   <= o_err_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign property_ready = o_ready_reg;
    assign key_offset     = o_koff_reg;
    assign key_length     = o_klen_reg;
    assign value_offset   = o_voff_reg;
    assign value_length   = o_vlen_reg;
    assign value_kind     = o_kind_reg;
    assign property_total = o_total_reg;
    assign document_ok    = o_ok_reg;
    assign error_code     = o_err_reg;

`ifndef SYNTH
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stk_depth <= DEPTH_MAX)
        else $error("closer stack depth past limit");

    a_nest_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_NEST && err_reg == fjs_pkg::ERR_NONE) |-> stk_depth != '0)
        else $error("nested phase with empty stack");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_final) |=> (pos_reg == '0 && stk_depth == '0
                                  && count_reg == '0 && phase_reg == PH_OPEN))
        else $error("document state not cleared after final byte");

    a_ready_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && o_ready_next) |=> (count_reg == $past(count_reg) + 11'd1
                                      || $past(is_final)))
        else $error("reported property not counted");
`endif

endmodule

### tb/flat_json_object_scanner_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flat_json_object_scanner_checker: result predictor and comparator
// Watches the input, output and config channels of the scanner, predicts the
// result beat of every accepted byte and compares it with the scanner's beat.
// ----------------------------------------------------------------------------
module flat_json_object_scanner_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  text_byte,
    input  logic        is_final,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        property_ready,
    input  logic [15:0] key_offset,
    input  logic [15:0] key_length,
    input  logic [15:0] value_offset,
    input  logic [15:0] value_length,
    input  logic [2:0]  value_kind,
    input  logic [10:0] property_total,
    input  logic        document_ok,
    input  logic [3:0]  error_code,
    input  logic        cfg_write,
    input  logic [10:0] cfg_data,
    output int          fail_count,
    output int          pending_count
);

    typedef enum logic [9:0] {
        S_OPEN    = 10'b0000000001,
        S_KEY     = 10'b0000000010,
        S_KEYBODY = 10'b0000000100,
        S_COLON   = 10'b0000001000,
        S_VAL     = 10'b0000010000,
        S_STR     = 10'b0000100000,
        S_TOKEN   = 10'b0001000000,
        S_NEST    = 10'b0010000000,
        S_COMMA   = 10'b0100000000,
        S_TAIL    = 10'b1000000000
    } scan_phase_t;

    typedef struct packed {
        logic        ready;
        logic [15:0] koff;
        logic [15:0] klen;
        logic [15:0] voff;
        logic [15:0] vlen;
        logic [2:0]  kind;
        logic [10:0] total;
        logic        ok;
        logic [3:0]  err;
    } scan_result_t;

    scan_result_t expected_beats[$];

    logic [10:0] prop_limit;
    scan_phase_t ph;
    logic [15:0] pos_r, kstart, klen_r, vstart;
    logic [2:0]  nkind;
    logic [1:0]  closers[fjs_pkg::NEST_DEPTH_DEF];
    int          depth;
    int          tlen;
    logic [7:0]  tfirst;
    logic [2:0]  kwm;
    logic        tnum, tdot;
    logic [10:0] count_r;
    logic [3:0]  err_r;

    function automatic logic [7:0] kw_char(int k, int i);
        string s;
        s = (k == 0) ? "null" : (k == 1) ? "true" : "false";
        return (i < s.len()) ? s[i] : 8'h00;
    endfunction

    task automatic clear_doc();
        ph = S_OPEN;
        pos_r = '0; kstart = '0; klen_r = '0; vstart = '0; nkind = '0;
        depth = 0; tlen = 0; tfirst = '0; kwm = '0; tnum = 1'b0; tdot = 1'b0;
        count_r = '0; err_r = fjs_pkg::ERR_NONE;
    endtask

    task automatic feed_token(logic [7:0] c);
        int klens[3];
        klens = '{4, 4, 5};
        for (int k = 0; k < 3; k++)
            if (!(tlen < klens[k] && c == kw_char(k, tlen))) kwm[k] = 1'b0;
        if (tlen == 0)
        begin
            tfirst = c; tnum = fjs_pkg::is_digit(c) || c == "-"; tdot = 1'b0;
        end
        else if (tfirst == "0") tnum = 1'b0;
        else if (tdot) tnum = tnum && fjs_pkg::is_digit(c);
        else if (c == ".") tdot = 1'b1;
        else tnum = tnum && fjs_pkg::is_digit(c);
        if (tlen < 7) tlen++;
    endtask

    function automatic logic [2:0] token_kind_or_bad(output logic bad);
        bad = 1'b0;
        if (tnum && !(tlen == 1 && tfirst == "-")) return fjs_pkg::KIND_NUMBER;
        if (tlen == 4 && kwm[0]) return fjs_pkg::KIND_NULL;
        if (tlen == 4 && kwm[1]) return fjs_pkg::KIND_TRUE;
        if (tlen == 5 && kwm[2]) return fjs_pkg::KIND_FALSE;
        bad = 1'b1;
        return fjs_pkg::KIND_STRING;
    endfunction

    task automatic push_closer(logic [1:0] code);
        if (depth >= fjs_pkg::NEST_DEPTH_DEF) err_r = fjs_pkg::ERR_OVERFLOW;
        else
        begin
            closers[depth] = code;
            depth++;
        end
    endtask

    task automatic finish_prop(inout scan_result_t r, input logic [2:0] kind,
                               input logic [15:0] vlen);
        if (count_r >= prop_limit)
        begin
            err_r = fjs_pkg::ERR_TOO_MANY;
            return;
        end
        count_r++;
        r.ready = 1'b1; r.koff = kstart; r.klen = klen_r; r.voff = vstart;
        r.vlen = vlen; r.kind = kind;
    endtask

    task automatic scan_byte(logic [7:0] c, logic fin);
        scan_result_t r;
        logic [15:0]  pos;
        logic         bad;
        logic [2:0]   k;
        logic [1:0]   code;
        r = '0;
        pos = pos_r;
        if (err_r == fjs_pkg::ERR_NONE)
        begin
            unique case (ph)
                S_OPEN:
                    if (c == "{") ph = S_KEY;
                    else if (!fjs_pkg::is_ws(c)) err_r = fjs_pkg::ERR_JUNK_OPEN;
                S_KEY:
                    if (c == "}") ph = S_TAIL;
                    else if (c == "\"")
                    begin
                        kstart = pos + 16'd1; ph = S_KEYBODY;
                    end
                    else if (!fjs_pkg::is_ws(c)) err_r = fjs_pkg::ERR_KEY_START;
                S_KEYBODY:
                    if (c == "\"")
                    begin
                        klen_r = pos - kstart;
                        if (klen_r == '0) err_r = fjs_pkg::ERR_EMPTY_KEY;
                        else ph = S_COLON;
                    end
                S_COLON:
                    if (c == ":") ph = S_VAL;
                    else if (!fjs_pkg::is_ws(c)) err_r = fjs_pkg::ERR_NO_COLON;
                S_VAL:
                    if (!fjs_pkg::is_ws(c))
                    begin
                        if (c == "}" || c == "]" || c == "(" || c == ")")
                            err_r = fjs_pkg::ERR_VAL_START;
                        else if (c == "\"")
                        begin
                            vstart = pos + 16'd1; ph = S_STR;
                        end
                        else if (c == "{" || c == "[")
                        begin
                            vstart = pos;
                            nkind = (c == "{") ? fjs_pkg::KIND_OBJECT : fjs_pkg::KIND_ARRAY;
                            depth = 0;
                            push_closer((c == "{") ? fjs_pkg::CL_BRACE : fjs_pkg::CL_BRACKET);
                            ph = S_NEST;
                        end
                        else if (c == ",") err_r = fjs_pkg::ERR_BAD_TOKEN;
                        else
                        begin
                            vstart = pos; tlen = 0; kwm = 3'b111;
                            feed_token(c);
                            ph = S_TOKEN;
                        end
                    end
                S_STR:
                    if (c == "\"")
                    begin
                        finish_prop(r, fjs_pkg::KIND_STRING, pos - vstart);
                        ph = S_COMMA;
                    end
                S_TOKEN:
                    if (fjs_pkg::is_ws(c) || c == "," || c == "}")
                    begin
                        k = token_kind_or_bad(bad);
                        if (bad) err_r = fjs_pkg::ERR_BAD_TOKEN;
                        else
                        begin
                            finish_prop(r, k, pos - vstart);
                            ph = (c == ",") ? S_KEY : (c == "}") ? S_TAIL : S_COMMA;
                        end
                    end
                    else feed_token(c);
                S_NEST:
                    if (depth == 0 || depth > fjs_pkg::NEST_DEPTH_DEF)
                        err_r = fjs_pkg::ERR_MISMATCH;
                    else if (c == "\"")
                    begin
                        if (depth == 1 || closers[depth - 1] != fjs_pkg::CL_QUOTE)
                            push_closer(fjs_pkg::CL_QUOTE);
                        else depth--;
                    end
                    else if (c == "{") push_closer(fjs_pkg::CL_BRACE);
                    else if (c == "[") push_closer(fjs_pkg::CL_BRACKET);
                    else if (c == "}" || c == "]")
                    begin
                        code = (c == "}") ? fjs_pkg::CL_BRACE : fjs_pkg::CL_BRACKET;
                        if (code != closers[depth - 1]) err_r = fjs_pkg::ERR_MISMATCH;
                        else if (depth == 1)
                        begin
                            depth = 0;
                            finish_prop(r, nkind, pos - vstart + 16'd1);
                            ph = S_COMMA;
                        end
                        else depth--;
                    end
                S_COMMA:
                    if (c == ",") ph = S_KEY;
                    else if (c == "}") ph = S_TAIL;
                    else if (!fjs_pkg::is_ws(c)) err_r = fjs_pkg::ERR_JUNK_AFTER;
                S_TAIL:
                    if (!fjs_pkg::is_ws(c)) err_r = fjs_pkg::ERR_TRAILING;
                default: ph = S_OPEN;
            endcase
        end
        pos_r = pos + 16'd1;
        r.total = count_r;
        if (fin)
        begin
            if (err_r == fjs_pkg::ERR_NONE && ph != S_TAIL) err_r = fjs_pkg::ERR_EARLY_END;
            r.ok = (err_r == fjs_pkg::ERR_NONE);
            r.err = err_r;
            clear_doc();
        end
        else r.err = err_r;
        expected_beats.push_back(r);
    endtask

    scan_result_t got, want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_limit = fjs_pkg::MAX_PROPS_RESET;
            clear_doc();
            expected_beats.delete();
            fail_count = 0;
            pending_count = 0;
        end
        else
        begin
            // Compare the result first: a byte and its own result never share an edge.
            if (out_valid && !out_stall)
            begin
                got = '{property_ready, key_offset, key_length, value_offset,
                        value_length, value_kind, property_total, document_ok, error_code};
                if (expected_beats.size() == 0)
                begin
                    $display("%0t: unexpected result beat %h", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: result mismatch expected %h actual %h", $time, want, got);
                        fail_count++;
                    end
                end
            end
            if (cfg_write) prop_limit = cfg_data;
            if (in_valid && !in_stall) scan_byte(text_byte, is_final);
            pending_count = expected_beats.size();
        end
    end

endmodule

### tb/flat_json_object_scanner_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flat_json_object_scanner_test: stimulus and verdict for the JSON scanner
// Feeds directed and random JSON documents through the scanner with random
// sender gaps and receiver stalls across several max_properties settings.
// ----------------------------------------------------------------------------
module flat_json_object_scanner_test;

    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  text_byte = 8'h00;
    logic        is_final = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        property_ready;
    logic [15:0] key_offset, key_length, value_offset, value_length;
    logic [2:0]  value_kind;
    logic [10:0] property_total;
    logic        document_ok;
    logic [3:0]  error_code;
    logic        cfg_write = 1'b0;
    logic [10:0] cfg_data = 11'd0;

    int fail_count, pending_count;
    int bytes_sent;
    int idle_cycles = 0;
    int gap_left;
    int burst_left;
    bit stall_free = 1'b0;

    always #5 clk = ~clk;

    flat_json_object_scanner i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .text_byte(text_byte), .is_final(is_final),
        .out_valid(out_valid), .out_stall(out_stall),
        .property_ready(property_ready), .key_offset(key_offset),
        .key_length(key_length), .value_offset(value_offset),
        .value_length(value_length), .value_kind(value_kind),
        .property_total(property_total), .document_ok(document_ok),
        .error_code(error_code), .cfg_write(cfg_write), .cfg_data(cfg_data)
    );

    flat_json_object_scanner_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .text_byte(text_byte), .is_final(is_final),
        .out_valid(out_valid), .out_stall(out_stall),
        .property_ready(property_ready), .key_offset(key_offset),
        .key_length(key_length), .value_offset(value_offset),
        .value_length(value_length), .value_kind(value_kind),
        .property_total(property_total), .document_ok(document_ok),
        .error_code(error_code), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // Receiver stall pattern: drifts between busy spells with random stalls and fully open spells.
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0) stall_free <= ~stall_free;
        if (stall_free) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(0, 3) == 0);
    end

    // Watchdog: count cycles with no beat accepted on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Send one byte: optional gap first, then hold valid until accepted.
    // Valid stays high between back-to-back beats of a burst.
    task automatic send_byte(logic [7:0] b, logic fin);
        if (burst_left == 0)
        begin
            gap_left = $urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 0;
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap_left) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid  <= 1'b1;
        text_byte <= b;
        is_final  <= fin;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    // Send a text; the final mark goes on its last byte.
    task automatic send_doc(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    endtask

    // Drain every pending result, then let the pipeline settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        burst_left = 0;
    endtask

    task automatic set_limit(logic [10:0] v);
        drain();
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic string rand_ws();
        string t[4];
        t = '{" ", "\t", "\n", "\r"};
        return ($urandom_range(0, 2) == 0) ? t[$urandom_range(0, 3)] : "";
    endfunction

    function automatic string rand_chars(int n, string pool);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, pool[$urandom_range(0, pool.len() - 1)]};
        return s;
    endfunction

    function automatic string rand_value();
        string tbl[12];
        tbl = '{"null", "true", "false", "0", "-", "5.", "-.5", "12.3.4",
                "nul", "truex", "01", "-42"};
        case ($urandom_range(0, 5))
            0: return {"\"", rand_chars($urandom_range(0, 4), "ab{[] }:,"), "\""};
            1: return tbl[$urandom_range(0, 11)];
            2: return {"[", rand_chars($urandom_range(0, 4), "1,\"ab "), "]"};
            3: return {"{\"", rand_chars($urandom_range(1, 3), "xy[]"), "\":", "[{}]}"};
            4: return rand_chars($urandom_range(1, 6), "0123456789.");
            default: return {"{", rand_chars($urandom_range(0, 5), "{[]}\"a"), "}"};
        endcase
    endfunction

    // Object with random, often invalid values; occasionally corrupted or cut short.
    function automatic string rand_doc();
        string s;
        int    n;
        n = $urandom_range(0, 6);
        s = {rand_ws(), "{"};
        for (int i = 0; i < n; i++)
        begin
            if (i > 0) s = {s, rand_ws(), ","};
            s = {s, rand_ws(), "\"", rand_chars($urandom_range(1, 4), "kq z"), "\"",
                 rand_ws(), ":", rand_ws(), rand_value(), rand_ws()};
        end
        s = {s, "}", rand_ws()};
        if ($urandom_range(0, 7) == 0)
            s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 15) == 0) s = s.substr(0, $urandom_range(0, s.len() - 1));
        return s;
    endfunction

    string directed[];
    string deep;

    initial
    begin
        burst_left = 0;
        bytes_sent = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: every error kind but too-many, every value kind, number corner cases.
        directed = '{
            "{\"a\":\"xy\",\"b\":5.,\"c\":-.5,\"d\":null,\"e\":true,\"f\":false}",
            " {\"o\":{\"q\":[1,\"]\"]},\"r\":[{}] }\t\r\n",
            "x{}", "{x}", "{\"\":1}", "{\"a\":1", "{\"a\" 1}", "{\"a\":}",
            "{\"a\":-}", "{\"a\":01}", "{\"a\":,}", "{\"a\":[}]}",
            "{\"a\":\"s\" x}", "{} x", "{}", "{\"a\":0}",
            {8'hff, "{}"}, {"{\"", 8'h80, "\":", 8'h00, "}"}
        };
        foreach (directed[i]) send_doc(directed[i]);
        deep = "{\"a\":";
        for (int i = 0; i < fjs_pkg::NEST_DEPTH_DEF + 1; i++) deep = {deep, "["};
        send_doc({deep, "]}"});

        // Limit settings: one property, then a limit of 1024.
        set_limit(11'd1);
        send_doc("{\"a\":1,\"b\":2}");
        set_limit(11'd1024);
        send_doc("{\"a\":true}");

        // Pause until every result is back before the random phases.
        drain();
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: set_limit(11'd3);
                1: set_limit(11'd64);
                2: set_limit(11'($urandom_range(1, 6)));
                default: set_limit(11'd2047);
            endcase
            while (bytes_sent < 150 + (ph + 1) * 200)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_doc(rand_chars($urandom_range(1, 12), "{}[]\":, ab1"));
                else send_doc(rand_doc());
            end
        end

        drain();
        repeat (10) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
